// File: rtl/core/lislt_pkg.sv
package lislt_pkg;

    localparam int MAX_LEN    = 1024;
    localparam int VALUE_BITS = 20;
    localparam int LEN_BITS   = $clog2(MAX_LEN + 1);
    localparam int RUN_BITS   = 11;

    typedef struct packed {
        logic [VALUE_BITS-1:0] sample_value;
        logic                  seq_end;
    } lislt_in_t;

    typedef struct packed {
        logic [RUN_BITS-1:0] run_length;
        logic                store_overflow;
    } lislt_out_t;

    typedef struct packed {
        logic                  valid;
        logic [VALUE_BITS-1:0] value;
        logic                  last;
        logic                  placed;
        logic                  grew;
    } lislt_token_t;

endpackage

// File: rtl/core/lislt_cell.sv
module lislt_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  lislt_pkg::lislt_token_t token_in,
    output lislt_pkg::lislt_token_t token_out
);
    import lislt_pkg::*;

    logic [VALUE_BITS-1:0] tail_reg;
    logic [VALUE_BITS-1:0] tail_next;
    logic                  occupied_reg;
    logic                  occupied_next;
    lislt_token_t          token_reg;
    lislt_token_t          token_next;

    always_comb begin
        token_next    = token_in;
        tail_next     = tail_reg;
        occupied_next = occupied_reg;
        if (token_in.valid && !token_in.placed) begin
            if (occupied_reg) begin
                if (tail_reg >= token_in.value) begin
                    tail_next         = token_in.value;
                    token_next.placed = 1'b1;
                end
            end else begin
                tail_next         = token_in.value;
                occupied_next     = 1'b1;
                token_next.placed = 1'b1;
                token_next.grew   = 1'b1;
            end
        end
        // end of sequence empties the cell once the transaction has passed
        if (token_in.valid && token_in.last) begin
            occupied_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occupied_reg <= 1'b0;
            token_reg    <= '0;
        end else if (advance) begin
            occupied_reg <= occupied_next;
            token_reg    <= token_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            tail_reg <= tail_next;
        end
    end

    assign token_out = token_reg;

endmodule

// File: rtl/core/lislt_tally.sv
module lislt_tally (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lislt_pkg::lislt_token_t end_token,
    input  logic                   m_ready,
    output logic                   advance,
    output logic                   m_valid,
    output lislt_pkg::lislt_out_t  m_data
);
    import lislt_pkg::*;

    logic [LEN_BITS-1:0] len_reg;
    logic [LEN_BITS-1:0] len_next;
    logic [LEN_BITS-1:0] len_sum;
    logic                m_valid_reg;
    lislt_out_t          out_reg;
    lislt_out_t          out_next;

    assign advance = !m_valid_reg || m_ready;
    assign len_sum = len_reg + LEN_BITS'(end_token.grew);

    always_comb begin
        out_next.run_length     = RUN_BITS'(len_sum);
        out_next.store_overflow = !end_token.placed;
        len_next                = len_reg;
        if (end_token.valid) begin
            len_next = end_token.last ? '0 : len_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            len_reg     <= len_next;
            m_valid_reg <= end_token.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && end_token.valid) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// File: rtl/core/lis_length_tracker.sv
// lis_length_tracker: streaming longest strictly increasing subsequence length
//
// s_ channel: one transaction per sequence element (sample_value, seq_end).
// m_ channel: one transaction per element, carrying the subsequence length so
// far (run_length) and store_overflow when the element needed a new tail but
// all MAX_LEN tails were in use.
// the tails live in a chain of MAX_LEN cells; each element walks the chain
// one cell per cycle unless held, replaces the first tail >= itself or claims
// the first empty cell, then the output stage adds any growth to the length counter.
// throughput: one transaction per cycle while the receiver does not stall,
// elements trail each other down the chain. the first cell registers an
// element at acceptance, each later cell registers it in turn, and the
// output register loads after the last cell.
// seq_end empties every cell behind the marked element and clears the length
// after its result, so the next element opens a new sequence.
// reset empties all cells and the length counter; no clearing pass is needed.
// when the receiver stalls with a result waiting, the whole chain holds and
// s_ready drops until m_ready returns.
module lis_length_tracker (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lislt_pkg::lislt_in_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output lislt_pkg::lislt_out_t m_data
);
    import lislt_pkg::*;

    lislt_token_t chain [MAX_LEN+1];
    logic         advance;

    always_comb begin
        chain[0].valid  = s_valid;
        chain[0].value  = s_data.sample_value;
        chain[0].last   = s_data.seq_end;
        chain[0].placed = 1'b0;
        chain[0].grew   = 1'b0;
    end

    for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
        lislt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .token_in  (chain[i]),
            .token_out (chain[i+1])
        );
    end

    lislt_tally u_tally (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .end_token (chain[MAX_LEN]),
        .m_ready   (m_ready),
        .advance   (advance),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

    assign s_ready = advance;

endmodule

// File: rtl/core/lislt_checker.sv
module lislt_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input lislt_pkg::lislt_in_t  s_data,
    input logic                  m_valid,
    input logic                  m_ready,
    input lislt_pkg::lislt_out_t m_data
);
    import lislt_pkg::*;

    // result holds while the receiver stalls
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped under stall");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result present after reset");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.store_overflow |-> m_data.run_length == RUN_BITS'(MAX_LEN))
        else $error("overflow below full length");

    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.run_length != '0)
        else $error("zero run length reported");

    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready out of step with output stage");

endmodule

bind lis_length_tracker lislt_checker u_lislt_checker (.*);
